// ===== rtl/arcs_pkg.sv =====
// Package for the atom-type / ring-block similarity block.
// Holds histogram sizes, divider step counts, the sequencer state type and helpers.
// No dependencies.
`default_nettype none

package arcs_pkg;

   // Histogram geometry.
   localparam int ATOM_TYPES        = 12;
   localparam int RING_SIZE_MAX     = 8;
   localparam int DESCRIPTOR_LENGTH = 20;

   // Atom types up to this one, and from the next constant on, are acyclic.
   localparam int ACYCLIC_LOW_LAST  = 4;
   localparam int ACYCLIC_HIGH_FIRST = 9;

   // Ring entries weigh index + 2, block entries index - RING_SIZE_MAX + 4.
   localparam int RING_WEIGHT_OFFSET  = 2;
   localparam int BLOCK_WEIGHT_OFFSET = 4;

   // Accumulator limits.
   localparam logic [12:0] MAX13 = 13'h1fff;
   localparam logic [16:0] MAX17 = 17'h1ffff;

   // Q1.16 one.
   localparam logic [16:0] Q_ONE = 17'h10000;

   // Ceiling of 2^19 / 3. The product with any sum below 2^19, shifted right by 19,
   // gives the exact truncated third.
   localparam logic [17:0] THIRD_RECIP = 18'd174763;

   // Step count of the shared ratio divider.
   localparam logic [4:0]  RATIO_STEPS   = 5'd16;

   // Merge modes of the cyclic sums.
   localparam logic [1:0] MODE_AVERAGE = 2'd0;
   localparam logic [1:0] MODE_MINIMUM = 2'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MERGE,
      S_SETUP,
      S_RATIO,
      S_OUT
   } state_type;

   function automatic logic [12:0] sat_add13(input logic [12:0] acc, input logic [7:0] val);
      logic [13:0] sum;
      sum = 14'(acc) + 14'(val);
      return sum[13] ? MAX13 : sum[12:0];
   endfunction

   function automatic logic [16:0] sat_add17(input logic [16:0] acc, input logic [13:0] val);
      logic [17:0] sum;
      sum = 18'(acc) + 18'(val);
      return sum[17] ? MAX17 : sum[16:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/atom_ring_combined_similarity_top.sv =====
// Top level of the atom-type / ring-block similarity block.
// Accumulates histogram pairs and forms the ratio with one shared restoring divider.
// Depends on arcs_pkg.
//
// Usage: histogram entries of molecules A and B enter one pair per item on the req_
// channel. The req_type field selects the atom-type histogram or the ring/block
// histogram, and req_position gives the entry index. An item without req_last is
// absorbed into the running sums, so such items can be sent back to back.
// An item with req_last is absorbed too, and then the block forms the result and
// holds req_stall high until that result has been taken on the rsp_ channel.
// The result follows the last item through the states S_MERGE, S_SETUP and S_RATIO:
// S_MERGE merges the cyclic sums (the truncated average of merge mode 0 comes from a
// multiply by the reciprocal of three), S_SETUP checks the ratio operands, and one
// shared subtract-and-shift divider then does 16 steps for the Q1.16 ratio in S_RATIO;
// a denominator of zero or below, or a ratio of one or more, skips the ratio steps.
// The result waits in its register while rsp_stall is high; the sums are cleared
// when it is taken, and the block accepts items again in the next cycle.
// Reset is synchronous; it clears all sums, returns the merge mode to 0 (average)
// and drops rsp_valid. The merge mode register is written through csr_write_enable
// and csr_write_data; the user must write it only while idle, which is not checked.
`default_nettype none

module atom_ring_combined_similarity_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [4:0]  req_position,
   input  wire logic [7:0]  req_count_a,
   input  wire logic [7:0]  req_count_b,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [16:0]      rsp_similarity,
   output logic             rsp_empty_pair
);
   import arcs_pkg::*;

   state_type   state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;

   // Running sums of the current comparison.
   logic [12:0] total_a_ff, total_a_in;
   logic [12:0] total_b_ff, total_b_in;
   logic [12:0] acyclic_ff, acyclic_in;
   logic [12:0] cyclic_ff, cyclic_in;
   logic [16:0] ring_ff, ring_in;
   logic [16:0] block_ff, block_in;

   // Merged cyclic part and the shared divider.
   logic [15:0] cyc_ff, cyc_in;
   logic [13:0] rem_ff, rem_in;
   logic [13:0] divisor_ff, divisor_in;
   logic [15:0] quo_ff, quo_in;
   logic [4:0]  count_ff, count_in;

   // Result register.
   logic [16:0] sim_ff, sim_in;
   logic        empty_ff, empty_in;

   logic        accept;
   logic [7:0]  pair_min;
   logic        atom_hit, ring_block_hit, is_ring, is_acyclic;
   logic [5:0]  weight;
   logic [13:0] weighted;

   logic [12:0] ring_clip;
   logic [17:0] cyc_sum;
   logic [16:0] cyc_min;
   logic [35:0] cyc_prod;
   logic [15:0] cyc_avg;

   logic [14:0] trial;
   logic        fits;
   logic [13:0] rem_next;
   logic [15:0] quo_next;

   logic [16:0] common;
   logic [18:0] denom;
   logic        denom_pos;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign pair_min  = (req_count_a < req_count_b) ? req_count_a : req_count_b;

   // Entry classification and weight of a ring or block entry.
   always_comb begin
      atom_hit       = !req_type && (32'(req_position) < ATOM_TYPES);
      ring_block_hit = req_type && (req_position != 5'd0)
                       && (32'(req_position) < DESCRIPTOR_LENGTH);
      is_ring        = (32'(req_position) + 1) < RING_SIZE_MAX;
      is_acyclic     = (32'(req_position) <= ACYCLIC_LOW_LAST)
                       || (32'(req_position) >= ACYCLIC_HIGH_FIRST);
      if (is_ring) begin
         weight = 6'(32'(req_position) + RING_WEIGHT_OFFSET);
      end else begin
         weight = 6'(32'(req_position) + BLOCK_WEIGHT_OFFSET - RING_SIZE_MAX);
      end
      weighted = 14'(pair_min) * 14'(weight);
   end

   // Cyclic merge operands: ring common is clipped to the atom cyclic common.
   // The sum of the three stays below 2^18, so the reciprocal product is exact.
   always_comb begin
      ring_clip = (ring_ff < 17'(cyclic_ff)) ? ring_ff[12:0] : cyclic_ff;
      cyc_sum   = 18'(cyclic_ff) + 18'(ring_clip) + 18'(block_ff);
      cyc_min   = (ring_clip < cyclic_ff) ? 17'(ring_clip) : 17'(cyclic_ff);
      if (block_ff < cyc_min) begin
         cyc_min = block_ff;
      end
      cyc_prod  = 36'(cyc_sum) * 36'(THIRD_RECIP);
      cyc_avg   = cyc_prod[34:19];
   end

   // One step of the shared restoring divider; the dividend bits shifted in are zero.
   always_comb begin
      trial    = {rem_ff, 1'b0};
      fits     = trial >= {1'b0, divisor_ff};
      rem_next = fits ? 14'(trial - {1'b0, divisor_ff}) : trial[13:0];
      quo_next = {quo_ff[14:0], fits};
   end

   // Ratio operands.
   always_comb begin
      common    = 17'(acyclic_ff) + 17'(cyc_ff);
      denom     = 19'(total_a_ff) + 19'(total_b_ff) - 19'(common);
      denom_pos = !denom[18] && (denom != 19'd0);
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = csr_write_enable ? csr_write_data : mode_ff;
      total_a_in = total_a_ff;
      total_b_in = total_b_ff;
      acyclic_in = acyclic_ff;
      cyclic_in  = cyclic_ff;
      ring_in    = ring_ff;
      block_in   = block_ff;
      cyc_in     = cyc_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      count_in   = count_ff;
      sim_in     = sim_ff;
      empty_in   = empty_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (atom_hit) begin
                  total_a_in = sat_add13(total_a_ff, req_count_a);
                  total_b_in = sat_add13(total_b_ff, req_count_b);
                  if (is_acyclic) begin
                     acyclic_in = sat_add13(acyclic_ff, pair_min);
                  end else begin
                     cyclic_in = sat_add13(cyclic_ff, pair_min);
                  end
               end
               if (ring_block_hit) begin
                  if (is_ring) begin
                     ring_in = sat_add17(ring_ff, weighted);
                  end else begin
                     block_in = sat_add17(block_ff, weighted);
                  end
               end
               if (req_last) begin
                  state_in = S_MERGE;
               end
            end
         end
         S_MERGE: begin
            if (mode_ff == MODE_AVERAGE) begin
               cyc_in = cyc_avg;
            end else if (mode_ff == MODE_MINIMUM) begin
               cyc_in = 16'(cyc_min);
            end else begin
               // Mode 2 and the unused code both drop the cyclic part.
               cyc_in = 16'd0;
            end
            state_in = S_SETUP;
         end
         S_SETUP: begin
            if (!denom_pos) begin
               sim_in   = '0;
               empty_in = 1'b1;
               state_in = S_OUT;
            end else if (19'(common) >= denom) begin
               sim_in   = Q_ONE;
               empty_in = 1'b0;
               state_in = S_OUT;
            end else begin
               // Here common is below the denominator, so both fit 14 bits.
               rem_in     = common[13:0];
               divisor_in = denom[13:0];
               quo_in     = '0;
               count_in   = RATIO_STEPS;
               state_in   = S_RATIO;
            end
         end
         S_RATIO: begin
            rem_in   = rem_next;
            quo_in   = quo_next;
            count_in = count_ff - 5'd1;
            if (count_ff == 5'd1) begin
               sim_in   = {1'b0, quo_next};
               empty_in = 1'b0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               total_a_in = '0;
               total_b_in = '0;
               acyclic_in = '0;
               cyclic_in  = '0;
               ring_in    = '0;
               block_in   = '0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mode_ff    <= MODE_AVERAGE;
         total_a_ff <= '0;
         total_b_ff <= '0;
         acyclic_ff <= '0;
         cyclic_ff  <= '0;
         ring_ff    <= '0;
         block_ff   <= '0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         total_a_ff <= total_a_in;
         total_b_ff <= total_b_in;
         acyclic_ff <= acyclic_in;
         cyclic_ff  <= cyclic_in;
         ring_ff    <= ring_in;
         block_ff   <= block_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cyc_ff     <= cyc_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
      sim_ff     <= sim_in;
      empty_ff   <= empty_in;
   end

   assign rsp_valid      = (state_ff == S_OUT);
   assign rsp_similarity = sim_ff;
   assign rsp_empty_pair = empty_ff;

   // No new item is taken while a result is pending.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("item accepted while a result is pending");

   // An empty pair always reports zero similarity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_pair) |-> (rsp_similarity == 17'd0))
      else $error("empty pair with nonzero similarity");

   // The ratio never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_similarity <= Q_ONE))
      else $error("similarity above one");

   // During the ratio steps the partial remainder stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RATIO) |-> (rem_ff < divisor_ff))
      else $error("divider remainder out of range");

endmodule

`default_nettype wire
